[design/assert_macros.svh]
// Assertion macros shared by the design files.
// Every macro expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define CMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the following cycle.
`define CMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cma_pkg.sv]
// Shared types and constants of the centered moving average block.
// No dependencies; imported by the divider and the top level.
package cma_pkg;

  // Field widths fixed by the interface.
  localparam int RADIUS_W    = 5;
  localparam int DIVISOR_W   = RADIUS_W + 1;
  localparam int AVG_W       = 17;
  localparam int OUT_TDATA_W = ((AVG_W + 7) / 8) * 8;

  // Marker for a position whose window is incomplete.
  localparam logic [AVG_W-1:0] NEG_ONE = {AVG_W{1'b1}};

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[design/centered_moving_average_core.sv]
// Centered moving average over a stream of unsigned samples, one result per position.
// Depends on cma_pkg, cma_ram, cma_divider and assert_macros.svh.
//
// Usage. Samples enter on the slave stream (s_axis_*), tlast closing a sequence. Each
// input transaction yields the result for the position k samples back: the truncated
// mean of the 2k+1 samples centered on it, or -1 (all ones) where the window runs past
// the start of the sequence. The transaction carrying tlast also yields the k pending
// positions as -1, and the final result of the sequence leaves with tlast set. Results
// leave on the master stream (m_axis_*) through an output register. The radius k is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while the block is
// idle, which the block does not enforce itself. Values above MAX_RADIUS are clamped.
// Operation. The block takes one sample at a time and takes no new sample until it has
// passed the results of the last one to the output register. A full window's mean comes
// from the divider loop, which gives one quotient bit per cycle. When the previous sum
// cannot be reused (first full window of a sequence or after a radius change) a sweep
// over the sample RAM rebuilds it. Positions with an incomplete window and the
// trailing -1 results are given without the divider.
// Reset clears all control state; the sample RAM needs no clearing pass because only
// entries written in the current sequence are read. While the receiver stalls, the
// output register holds its result and the block still takes the next sample.
`include "assert_macros.svh"

module centered_moving_average_core #(
  parameter int MAX_RADIUS  = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: radius register.
  input  logic                            cfg_we_i,
  input  logic [cma_pkg::RADIUS_W-1:0]    cfg_wdata_i,
  // Slave stream. tdata fields from bit 0: sample.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                            s_axis_tlast,
  // Master stream. tdata fields from bit 0: average (17 bits signed), zero fill.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import cma_pkg::*;

  // The store must keep the widest window plus the sample that just left it.
  localparam int DEPTH = 2 ** $clog2(2 * MAX_RADIUS + 2);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SUM_W = SAMPLE_BITS + PTR_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DROP = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_TAIL = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [RADIUS_W-1:0]    radius_q;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [PTR_W-1:0]       seen_q, seen_d;
  logic [PTR_W-1:0]       base_q, base_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   sum_ok_q, sum_ok_d;
  logic [DIVISOR_W-1:0]   sum_w_q, sum_w_d;
  logic [DIVISOR_W-1:0]   width_q, width_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [DIVISOR_W-1:0]   cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic [RADIUS_W-1:0]    tail_q, tail_d;
  logic                   last_q, last_d;
  logic [AVG_W-1:0]       avg_q, avg_d;
  logic                   start_q, start_d;
  logic                   out_valid_q, out_valid_d;
  logic [AVG_W-1:0]       out_avg_q, out_avg_d;
  logic                   out_last_q, out_last_d;

  logic                   accept;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [RADIUS_W-1:0]    k_act;
  logic [DIVISOR_W-1:0]   width_act;
  logic [PTR_W-1:0]       wp_new;
  logic [PTR_W-1:0]       seen_new;
  logic [DIVISOR_W-1:0]   seen_ext;
  logic                   due;
  logic                   full;
  logic [RADIUS_W-1:0]    pending;
  logic [PTR_W-1:0]       raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SUM_W-1:0]       quotient;
  logic [AVG_W+SUM_W-1:0] quo_ext;
  div_status_t            div_status;

  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // Active radius and window width 2k+1.
  assign k_act     = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign width_act = {k_act, 1'b1};

  assign wp_new   = wp_q + PTR_W'(1);
  assign seen_new = (seen_q == PTR_W'(DEPTH - 1)) ? seen_q : seen_q + PTR_W'(1);
  assign seen_ext = DIVISOR_W'(seen_new);
  assign due      = seen_ext >= ({1'b0, k_act} + DIVISOR_W'(1));
  assign full     = seen_ext >= width_act;
  assign pending  = (seen_ext < {1'b0, k_act}) ? RADIUS_W'(seen_new) : k_act;

  // While idle the read port fetches the sample that leaves the window, so a reused sum
  // can be updated in one step. During a sweep it walks back from the newest sample.
  always_comb begin
    if (state_q == ST_SUM) begin
      raddr = base_q - PTR_W'(1) - PTR_W'(cnt_q);
    end else begin
      raddr = wp_q - PTR_W'(width_act);
    end
  end

  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (in_sample),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cma_divider #(
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (sum_q),
    .divisor_i  (width_q),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  // The mean is kept to its 17 bits; narrow sums are zero extended.
  assign quo_ext = {{AVG_W{1'b0}}, quotient};

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    seen_d      = seen_q;
    base_d      = base_q;
    sum_d       = sum_q;
    sum_ok_d    = sum_ok_q;
    sum_w_d     = sum_w_q;
    width_d     = width_q;
    sample_d    = sample_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    tail_d      = tail_q;
    last_d      = last_q;
    avg_d       = avg_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_avg_d   = out_avg_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sample_d = in_sample;
          width_d  = width_act;
          base_d   = wp_new;
          last_d   = s_axis_tlast;
          tail_d   = s_axis_tlast ? pending : '0;
          wp_d     = s_axis_tlast ? '0 : wp_new;
          seen_d   = s_axis_tlast ? '0 : seen_new;
          if (due && full) begin
            if (sum_ok_q && (sum_w_q == width_act)) begin
              state_d = ST_DROP;
            end else begin
              sum_d   = '0;
              cnt_d   = '0;
              state_d = ST_SUM;
            end
          end else if (due) begin
            sum_ok_d = 1'b0;
            avg_d    = NEG_ONE;
            state_d  = ST_EMIT;
          end else begin
            sum_ok_d = 1'b0;
            state_d  = s_axis_tlast ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_DROP: begin
        // Slide the window: the new sample enters, the oldest one leaves.
        sum_d   = sum_q + SUM_W'(sample_q) - SUM_W'(rdata);
        start_d = 1'b1;
        state_d = ST_DIV;
      end
      ST_SUM: begin
        if (cnt_q < width_q) begin
          cnt_d  = cnt_q + DIVISOR_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + SUM_W'(rdata);
        end
        if ((cnt_q == width_q) && !pend_q) begin
          start_d = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          avg_d    = quo_ext[AVG_W-1:0];
          sum_ok_d = !last_q;
          sum_w_d  = width_q;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_avg_d   = avg_q;
          out_last_d  = last_q && (tail_q == '0);
          state_d     = (tail_q != '0) ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_avg_d   = NEG_ONE;
          out_last_d  = tail_q == RADIUS_W'(1);
          tail_d      = tail_q - RADIUS_W'(1);
          if (tail_q == RADIUS_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= '0;
      wp_q        <= '0;
      seen_q      <= '0;
      sum_ok_q    <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      tail_q      <= '0;
      last_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      wp_q        <= wp_d;
      seen_q      <= seen_d;
      sum_ok_q    <= sum_ok_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      tail_q      <= tail_d;
      last_q      <= last_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    sum_q      <= sum_d;
    sum_w_q    <= sum_w_d;
    width_q    <= width_d;
    sample_q   <= sample_d;
    avg_q      <= avg_d;
    out_avg_q  <= out_avg_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_avg_q);
  assign m_axis_tlast  = out_last_q;

  // A divider result is only expected while the sequencer waits for it.
  `CMA_ASSERT_IMP(a_div_done_in_div, div_status.done, state_q == ST_DIV,
                  "divider finished outside the divide state")
  // A new division never starts on top of a running one.
  `CMA_ASSERT_IMP(a_start_idle_div, start_q, !div_status.busy,
                  "divider restarted while busy")
  // The trailing run is entered only with positions left to give.
  `CMA_ASSERT_IMP(a_tail_nonzero, state_q == ST_TAIL, tail_q != '0,
                  "trailing state with no pending positions")
  // The sweep never reads beyond the window.
  `CMA_ASSERT_IMP(a_sweep_bound, state_q == ST_SUM, cnt_q <= width_q,
                  "window sweep ran past its width")
  // A sequence end clears the position state for the next one.
  `CMA_ASSERT_NXT(a_last_clears, accept && s_axis_tlast, (wp_q == '0) && (seen_q == '0),
                  "sequence end did not clear the write pointer and count")

endmodule

[design/cma_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cma_divider.sv]
// Restoring radix-2 divider producing one quotient bit per cycle.
// Depends on cma_pkg for the divisor width and the status struct.
module cma_divider #(
  parameter int DIVIDEND_W = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIVIDEND_W-1:0]         dividend_i,
  input  logic [cma_pkg::DIVISOR_W-1:0] divisor_i,
  output logic [DIVIDEND_W-1:0]         quotient_o,
  output cma_pkg::div_status_t          status_o
);
  import cma_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // The partial remainder stays below the divisor, so one extra bit covers the trial.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = DIVISOR_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = DIVISOR_W'(trial);
      end
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
